// ===== hdl/nnq_pkg.sv =====
// ----------------------------------------------------------------------------
// nnq_pkg
// Shared types, widths and note table helpers for the nearest note quantizer.
// ----------------------------------------------------------------------------
package nnq_pkg;

    // field widths
    localparam int FREQ_W  = 15;
    localparam int ERR_W   = 16;
    localparam int DIST_W  = 15;
    localparam int NOTE_W  = 4;
    localparam int OCT_W   = 3;
    localparam int STATE_W = 2;
    localparam int TOL_W   = 8;

    // table shape and fixed point
    localparam int NOTES          = 12;
    localparam int OCTAVES_DEF    = 4;
    localparam int FRAC_BITS_DEF  = 4;
    localparam int BASE_FRAC      = 16;
    localparam int FREQ_MAX       = 32767;
    localparam int OCTAVE_FIRST   = 2;
    localparam int GROUP          = 4;

    // tolerance after reset, one hertz at four fraction bits
    localparam logic [TOL_W-1:0] TOL_RESET = 8'd16;

    typedef enum logic [STATE_W-1:0] {
        TUNE_SHARP = 2'd0,
        TUNE_FLAT  = 2'd1,
        TUNE_IN    = 2'd2
    } tune_state_t;

    // octave-2 note frequencies with 16 fraction bits
    function automatic logic [31:0] base_freq(input int note);
        logic [31:0] f;
        unique case (note)
            0:       f = 32'd4286473;
            1:       f = 32'd4541360;
            2:       f = 32'd4811404;
            3:       f = 32'd5097505;
            4:       f = 32'd5400618;
            5:       f = 32'd5721755;
            6:       f = 32'd6061989;
            7:       f = 32'd6422453;
            8:       f = 32'd6804352;
            9:       f = 32'd7208960;
            10:      f = 32'd7637627;
            default: f = 32'd8091784;
        endcase
        return f;
    endfunction

    // table entry: base shifted up by octave column, rounded half up, saturated
    function automatic logic [FREQ_W-1:0] table_entry(input int note, input int col,
                                                      input int frac_bits);
        logic [63:0] v;
        int          sh;
        sh = BASE_FRAC - frac_bits;
        v  = 64'(base_freq(note)) << col;
        v  = (v + (64'd1 << (sh - 1))) >> sh;
        if (v > 64'(FREQ_MAX))
        begin
            v = 64'(FREQ_MAX);
        end
        return v[FREQ_W-1:0];
    endfunction

    // candidate count entering reduction stage k
    function automatic int stage_count(input int n, input int k);
        int c;
        c = n;
        for (int s = 0; s < k; s++)
        begin
            c = (c + GROUP - 1) / GROUP;
        end
        return c;
    endfunction

    // number of reduction stages down to one candidate
    function automatic int reduce_stages(input int n);
        int c;
        int s;
        c = n;
        s = 0;
        while (c > 1)
        begin
            c = (c + GROUP - 1) / GROUP;
            s++;
        end
        return s;
    endfunction

endpackage

// ===== hdl/nnq_if.sv =====
// ----------------------------------------------------------------------------
// nnq_if
// Request channels of the quantizer: measured frequency in, note result out.
// ----------------------------------------------------------------------------
interface nnq_in_if;
    import nnq_pkg::*;

    logic              valid;
    logic              ready;
    logic [FREQ_W-1:0] freq_hz;

    modport source (output valid, output freq_hz, input ready);
    modport sink   (input valid, input freq_hz, output ready);
endinterface

interface nnq_out_if;
    import nnq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [NOTE_W-1:0]        note_class;
    logic [OCT_W-1:0]         octave_number;
    logic [FREQ_W-1:0]        nearest_freq;
    logic signed [ERR_W-1:0]  freq_error;
    logic [STATE_W-1:0]       tune_state;

    modport source (output valid, output note_class, output octave_number,
                    output nearest_freq, output freq_error, output tune_state,
                    input ready);
    modport sink   (input valid, input note_class, input octave_number,
                    input nearest_freq, input freq_error, input tune_state,
                    output ready);
endinterface

// ===== hdl/nnq_dist.sv =====
// ----------------------------------------------------------------------------
// nnq_dist
// First stage: absolute distance from the measurement to every table entry.
// ----------------------------------------------------------------------------
module nnq_dist #(
    parameter int OCTAVES   = nnq_pkg::OCTAVES_DEF,
    parameter int FRAC_BITS = nnq_pkg::FRAC_BITS_DEF,
    parameter int N         = nnq_pkg::NOTES * OCTAVES
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic [nnq_pkg::FREQ_W-1:0]            in_freq,
    output logic                                  valid_reg,
    output logic [nnq_pkg::FREQ_W-1:0]            meas_reg,
    output logic [N-1:0][nnq_pkg::DIST_W-1:0]     dist_reg
);
    import nnq_pkg::*;

    logic [N-1:0][DIST_W-1:0] dist_next;

    // one subtract and magnitude per table entry
    for (genvar i = 0; i < N; i++)
    begin : g_entry
        localparam logic [FREQ_W-1:0] ENTRY =
            table_entry(i / OCTAVES, i % OCTAVES, FRAC_BITS);
        logic [ERR_W-1:0] d;
        assign d = {1'b0, ENTRY} - {1'b0, in_freq};
        assign dist_next[i] = d[ERR_W-1] ? DIST_W'(~d + 1'b1) : d[DIST_W-1:0];
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meas_reg <= in_freq;
            dist_reg <= dist_next;
        end
    end

endmodule

// ===== hdl/nnq_reduce.sv =====
// ----------------------------------------------------------------------------
// nnq_reduce
// One registered stage of the minimum search: four candidates to one.
// ----------------------------------------------------------------------------
module nnq_reduce #(
    parameter int N     = nnq_pkg::NOTES * nnq_pkg::OCTAVES_DEF,
    parameter int N_IN  = N,
    parameter int IDX_W = $clog2(N)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [nnq_pkg::FREQ_W-1:0]         in_meas,
    input  logic [N-1:0][nnq_pkg::DIST_W-1:0]  in_dist,
    input  logic [N-1:0][IDX_W-1:0]            in_idx,
    output logic                               valid_reg,
    output logic [nnq_pkg::FREQ_W-1:0]         meas_reg,
    output logic [N-1:0][nnq_pkg::DIST_W-1:0]  dist_out,
    output logic [N-1:0][IDX_W-1:0]            idx_out
);
    import nnq_pkg::*;

    localparam int N_OUT = (N_IN + GROUP - 1) / GROUP;

    logic [N_OUT-1:0][DIST_W-1:0] dist_next;
    logic [N_OUT-1:0][IDX_W-1:0]  idx_next;
    logic [N_OUT-1:0][DIST_W-1:0] dist_reg;
    logic [N_OUT-1:0][IDX_W-1:0]  idx_reg;

    // pairwise picks, the lower position wins a tie
    always_comb
    begin
        logic [GROUP-1:0][DIST_W-1:0] cd;
        logic [GROUP-1:0][IDX_W-1:0]  ci;
        logic [DIST_W-1:0]            d01;
        logic [DIST_W-1:0]            d23;
        logic [IDX_W-1:0]             i01;
        logic [IDX_W-1:0]             i23;
        for (int g = 0; g < N_OUT; g++)
        begin
            for (int m = 0; m < GROUP; m++)
            begin
                if (g * GROUP + m < N_IN)
                begin
                    cd[m] = in_dist[g * GROUP + m];
                    ci[m] = in_idx[g * GROUP + m];
                end
                else
                begin
                    cd[m] = '1;
                    ci[m] = '0;
                end
            end
            if (cd[1] < cd[0])
            begin
                d01 = cd[1];
                i01 = ci[1];
            end
            else
            begin
                d01 = cd[0];
                i01 = ci[0];
            end
            if (cd[3] < cd[2])
            begin
                d23 = cd[3];
                i23 = ci[3];
            end
            else
            begin
                d23 = cd[2];
                i23 = ci[2];
            end
            if (d23 < d01)
            begin
                dist_next[g] = d23;
                idx_next[g]  = i23;
            end
            else
            begin
                dist_next[g] = d01;
                idx_next[g]  = i01;
            end
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meas_reg <= in_meas;
            dist_reg <= dist_next;
            idx_reg  <= idx_next;
        end
    end

    // surviving candidates at the low positions, the rest tied off
    always_comb
    begin
        dist_out = '0;
        idx_out  = '0;
        for (int g = 0; g < N_OUT; g++)
        begin
            dist_out[g] = dist_reg[g];
            idx_out[g]  = idx_reg[g];
        end
    end

endmodule

// ===== hdl/nnq_result.sv =====
// ----------------------------------------------------------------------------
// nnq_result
// Last stage: table lookup of the winner, signed error, tune state, output.
// ----------------------------------------------------------------------------
module nnq_result #(
    parameter int OCTAVES   = nnq_pkg::OCTAVES_DEF,
    parameter int FRAC_BITS = nnq_pkg::FRAC_BITS_DEF,
    parameter int N         = nnq_pkg::NOTES * OCTAVES,
    parameter int IDX_W     = $clog2(N)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [nnq_pkg::FREQ_W-1:0]  in_meas,
    input  logic [IDX_W-1:0]            in_idx,
    input  logic [nnq_pkg::TOL_W-1:0]   tol,
    nnq_out_if.source                   res
);
    import nnq_pkg::*;

    logic [FREQ_W-1:0]        entry_tab [N];
    logic [NOTE_W-1:0]        note_tab [N];
    logic [OCT_W-1:0]         oct_tab [N];
    logic [FREQ_W-1:0]        freq;
    logic [ERR_W-1:0]         diff;
    logic [ERR_W-1:0]         mag;
    tune_state_t              state_next;

    logic                     valid_reg;
    logic [NOTE_W-1:0]        note_reg;
    logic [OCT_W-1:0]         oct_reg;
    logic [FREQ_W-1:0]        freq_reg;
    logic [ERR_W-1:0]         diff_reg;
    tune_state_t              state_reg;

    // constant note table with note class and octave per entry
    for (genvar i = 0; i < N; i++)
    begin : g_tab
        assign entry_tab[i] = table_entry(i / OCTAVES, i % OCTAVES, FRAC_BITS);
        assign note_tab[i]  = NOTE_W'(i / OCTAVES);
        assign oct_tab[i]   = OCT_W'(i % OCTAVES + OCTAVE_FIRST);
    end

    // error and its magnitude
    assign freq = entry_tab[in_idx];
    assign diff = {1'b0, freq} - {1'b0, in_meas};
    assign mag  = diff[ERR_W-1] ? (~diff + 1'b1) : diff;

    // tolerance band, its edges count as out of tune
    always_comb
    begin
        priority if (mag < ERR_W'(tol))
        begin
            state_next = TUNE_IN;
        end
        else if (diff[ERR_W-1])
        begin
            state_next = TUNE_SHARP;
        end
        else
        begin
            state_next = TUNE_FLAT;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            note_reg  <= note_tab[in_idx];
            oct_reg   <= oct_tab[in_idx];
            freq_reg  <= freq;
            diff_reg  <= diff;
            state_reg <= state_next;
        end
    end

    assign res.valid         = valid_reg;
    assign res.note_class    = note_reg;
    assign res.octave_number = oct_reg;
    assign res.nearest_freq  = freq_reg;
    assign res.freq_error    = diff_reg;
    assign res.tune_state    = state_reg;

endmodule

// ===== hdl/nearest_note_quantizer.sv =====
// ----------------------------------------------------------------------------
// nearest_note_quantizer
// Maps a measured frequency to the nearest equal-tempered note and grades it.
// ----------------------------------------------------------------------------
// Takes one measured frequency per clock unless the held output stalls it, and
// returns one result per request, in order: one stage forms all distances to
// the note table, then a tree of registered four-way minimum stages finds the
// nearest entry (lowest table index on a tie), and a last stage forms the
// signed error and tune state.
// The whole pipeline moves as one; when the output request is not taken it
// holds, and the input is ready again as soon as the output moves.
module nearest_note_quantizer #(
    parameter int OCTAVES   = nnq_pkg::OCTAVES_DEF,
    parameter int FRAC_BITS = nnq_pkg::FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [nnq_pkg::TOL_W-1:0]  cfg_wr_data,
    nnq_in_if.sink                     freq_in,
    nnq_out_if.source                  note_out
);
    import nnq_pkg::*;

    localparam int N      = NOTES * OCTAVES;
    localparam int IDX_W  = $clog2(N);
    localparam int STAGES = reduce_stages(N);

    logic                     pipe_en;
    logic [TOL_W-1:0]         tol_reg;

    logic                     valid_s [STAGES+1];
    logic [FREQ_W-1:0]        meas_s  [STAGES+1];
    logic [N-1:0][DIST_W-1:0] dist_s  [STAGES+1];
    logic [N-1:0][IDX_W-1:0]  idx_s   [STAGES+1];

    // pipeline advances unless a finished result is held
    assign pipe_en       = !note_out.valid || note_out.ready;
    assign freq_in.ready = pipe_en;

    // tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_wr_en)
        begin
            tol_reg <= cfg_wr_data;
        end
    end

    // distance stage
    nnq_dist #(
        .OCTAVES   (OCTAVES),
        .FRAC_BITS (FRAC_BITS),
        .N         (N)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (freq_in.valid),
        .in_freq   (freq_in.freq_hz),
        .valid_reg (valid_s[0]),
        .meas_reg  (meas_s[0]),
        .dist_reg  (dist_s[0])
    );

    // table positions as starting indexes
    for (genvar i = 0; i < N; i++)
    begin : g_idx
        assign idx_s[0][i] = IDX_W'(i);
    end

    // minimum search tree
    for (genvar k = 0; k < STAGES; k++)
    begin : g_red
        nnq_reduce #(
            .N     (N),
            .N_IN  (stage_count(N, k)),
            .IDX_W (IDX_W)
        ) u_reduce (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (pipe_en),
            .in_valid  (valid_s[k]),
            .in_meas   (meas_s[k]),
            .in_dist   (dist_s[k]),
            .in_idx    (idx_s[k]),
            .valid_reg (valid_s[k+1]),
            .meas_reg  (meas_s[k+1]),
            .dist_out  (dist_s[k+1]),
            .idx_out   (idx_s[k+1])
        );
    end

    // result stage
    nnq_result #(
        .OCTAVES   (OCTAVES),
        .FRAC_BITS (FRAC_BITS),
        .N         (N),
        .IDX_W     (IDX_W)
    ) u_result (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_valid (valid_s[STAGES]),
        .in_meas  (meas_s[STAGES]),
        .in_idx   (idx_s[STAGES][0]),
        .tol      (tol_reg),
        .res      (note_out)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nearest note quantizer. Frequency requests are
// queued by a sequencing block and sent by a clocked driver. Each accepted
// request is graded against a local note table and the tolerance copy. A
// clocked monitor compares every returned note request field by field, in
// order. Tolerance changes only while the pipeline is drained.
// ----------------------------------------------------------------------------
module tb_top;
    import nnq_pkg::*;

    localparam int TABLE_N  = NOTES * OCTAVES_DEF;
    localparam int ROUND_SH = BASE_FRAC - FRAC_BITS_DEF;
    localparam int PHASES   = 6;
    localparam int RAND_PER_PHASE = 300;

    typedef struct {
        logic [FREQ_W-1:0]       meas;
        logic [NOTE_W-1:0]       note;
        logic [OCT_W-1:0]        octave;
        logic [FREQ_W-1:0]       freq;
        logic signed [ERR_W-1:0] err;
        tune_state_t             state;
    } note_result_t;

    // octave-2 frequencies, 16 fraction bits
    localparam int unsigned OCT2_Q16 [NOTES] = '{
        4286473, 4541360, 4811404, 5097505, 5400618, 5721755,
        6061989, 6422453, 6804352, 7208960, 7637627, 8091784
    };

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [TOL_W-1:0]  cfg_wr_data;

    nnq_in_if  freq_in ();
    nnq_out_if note_out ();

    nearest_note_quantizer u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .freq_in     (freq_in),
        .note_out    (note_out)
    );

    int                note_freq [TABLE_N];
    int                tie_points [$];
    logic [FREQ_W-1:0] freq_backlog [$];
    note_result_t      pending_notes [$];
    logic [TOL_W-1:0]  tol_shadow;
    int                send_idle_pct;
    int                recv_idle_pct;
    int                freq_sent;
    int                freq_taken;
    int                mismatch_cnt;

    // nearest table entry, lowest index on a tie, graded against tolerance
    function automatic note_result_t grade_note(input logic [FREQ_W-1:0] meas,
                                                input logic [TOL_W-1:0] tol);
        note_result_t r;
        int           best_i;
        int           best_d;
        int           d;
        int           diff;
        int           mag;
        best_i = 0;
        best_d = 1 << 30;
        for (int i = 0; i < TABLE_N; i++)
        begin
            d = note_freq[i] - int'(meas);
            if (d < 0)
            begin
                d = -d;
            end
            if (d < best_d)
            begin
                best_d = d;
                best_i = i;
            end
        end
        diff     = note_freq[best_i] - int'(meas);
        mag      = (diff < 0) ? -diff : diff;
        r.meas   = meas;
        r.note   = NOTE_W'(best_i / OCTAVES_DEF);
        r.octave = OCT_W'(best_i % OCTAVES_DEF + OCTAVE_FIRST);
        r.freq   = FREQ_W'(note_freq[best_i]);
        r.err    = ERR_W'(diff);
        if (mag < int'(tol))
        begin
            r.state = TUNE_IN;
        end
        else if (diff < 0)
        begin
            r.state = TUNE_SHARP;
        end
        else
        begin
            r.state = TUNE_FLAT;
        end
        return r;
    endfunction

    function automatic logic [FREQ_W-1:0] clamp_freq(input int v);
        if (v < 0)
        begin
            return '0;
        end
        if (v > FREQ_MAX)
        begin
            return FREQ_W'(FREQ_MAX);
        end
        return FREQ_W'(v);
    endfunction

    task automatic write_tolerance(input logic [TOL_W-1:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        tol_shadow = v;
    endtask

    task automatic wait_drained();
        while (freq_backlog.size() != 0 || freq_sent != freq_taken ||
               pending_notes.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // sender: hold a request until taken, then maybe idle
    always @(negedge clk)
    begin
        if (freq_sent == freq_taken)
        begin
            if (freq_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                freq_in.valid   <= 1'b1;
                freq_in.freq_hz <= freq_backlog.pop_front();
                freq_sent++;
            end
            else
            begin
                freq_in.valid <= 1'b0;
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        note_out.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // grade accepted frequency requests
    always @(posedge clk)
    begin
        if (rst_n && freq_in.valid && freq_in.ready)
        begin
            freq_taken++;
            pending_notes.push_back(grade_note(freq_in.freq_hz, tol_shadow));
        end
    end

    // compare returned note requests with the oldest pending one
    always @(posedge clk)
    begin
        note_result_t want;
        if (rst_n && note_out.valid && note_out.ready)
        begin
            if (pending_notes.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                begin
                    $display("unexpected note: note=%0d oct=%0d freq=%0d err=%0d state=%0d",
                             note_out.note_class, note_out.octave_number,
                             note_out.nearest_freq, note_out.freq_error,
                             note_out.tune_state);
                end
            end
            else
            begin
                want = pending_notes.pop_front();
                if (note_out.note_class !== want.note ||
                    note_out.octave_number !== want.octave ||
                    note_out.nearest_freq !== want.freq ||
                    note_out.freq_error !== want.err ||
                    note_out.tune_state !== want.state)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                    begin
                        $display("mismatch for %0d: want note=%0d oct=%0d freq=%0d err=%0d state=%0d",
                                 want.meas, want.note, want.octave, want.freq,
                                 want.err, want.state);
                        $display("                 got  note=%0d oct=%0d freq=%0d err=%0d state=%0d",
                                 note_out.note_class, note_out.octave_number,
                                 note_out.nearest_freq, note_out.freq_error,
                                 note_out.tune_state);
                    end
                end
            end
        end
    end

    // sequencing: reset, directed requests, then random phases
    initial
    begin
        int                sorted [TABLE_N];
        int                t;
        int                k;
        int                idx;
        int                off;
        int                a4;
        logic [TOL_W-1:0]  tol_plan [PHASES];

        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        freq_in.valid   = 1'b0;
        freq_in.freq_hz = '0;
        note_out.ready  = 1'b0;
        freq_sent       = 0;
        freq_taken      = 0;
        mismatch_cnt    = 0;
        tol_shadow      = TOL_RESET;
        send_idle_pct   = 27;
        recv_idle_pct   = 67;

        // note table: base shifted by octave column, rounded half up
        for (int i = 0; i < TABLE_N; i++)
        begin
            longint v;
            v = longint'(OCT2_Q16[i / OCTAVES_DEF]) << (i % OCTAVES_DEF);
            v = (v + (longint'(1) << (ROUND_SH - 1))) >> ROUND_SH;
            note_freq[i] = (v > FREQ_MAX) ? FREQ_MAX : int'(v);
            sorted[i]    = note_freq[i];
        end
        // midpoints between neighbors in pitch are distance ties
        for (int i = 0; i < TABLE_N - 1; i++)
        begin
            for (int j = 0; j < TABLE_N - 1 - i; j++)
            begin
                if (sorted[j] > sorted[j + 1])
                begin
                    t             = sorted[j];
                    sorted[j]     = sorted[j + 1];
                    sorted[j + 1] = t;
                end
            end
        end
        for (int i = 0; i < TABLE_N - 1; i++)
        begin
            if (((sorted[i] + sorted[i + 1]) % 2) == 0)
            begin
                tie_points.push_back((sorted[i] + sorted[i + 1]) / 2);
            end
        end

        tol_plan = '{TOL_RESET, 8'd0, 8'd255, TOL_W'($urandom_range(254, 2)), 8'd1,
                     TOL_RESET};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, exact note, tolerance edges, ties
        a4 = note_freq[9 * OCTAVES_DEF + 2];
        freq_backlog.push_back(FREQ_W'(0));
        freq_backlog.push_back(FREQ_W'(1));
        freq_backlog.push_back(FREQ_W'(FREQ_MAX));
        freq_backlog.push_back(FREQ_W'(FREQ_MAX - 1));
        freq_backlog.push_back(FREQ_W'(16384));
        freq_backlog.push_back(FREQ_W'(15'h2AAA));
        freq_backlog.push_back(FREQ_W'(15'h5555));
        freq_backlog.push_back(clamp_freq(a4));
        freq_backlog.push_back(clamp_freq(a4 + int'(tol_shadow)));
        freq_backlog.push_back(clamp_freq(a4 - int'(tol_shadow)));
        freq_backlog.push_back(clamp_freq(a4 + int'(tol_shadow) - 1));
        freq_backlog.push_back(clamp_freq(a4 - int'(tol_shadow) + 1));
        freq_backlog.push_back(clamp_freq(sorted[0]));
        freq_backlog.push_back(clamp_freq(sorted[0] - 1));
        freq_backlog.push_back(clamp_freq(sorted[TABLE_N - 1]));
        freq_backlog.push_back(clamp_freq(sorted[TABLE_N - 1] + 1));
        for (int i = 0; i < 4 && i < tie_points.size(); i++)
        begin
            freq_backlog.push_back(clamp_freq(tie_points[i]));
        end
        freq_backlog.push_back(clamp_freq(tie_points[tie_points.size() - 1]));

        for (int p = 0; p < PHASES; p++)
        begin
            // sender holds off until every pending note is back
            wait_drained();
            if (p != 0)
            begin
                write_tolerance(tol_plan[p]);
            end
            send_idle_pct = (p < 2) ? 27 : (p < 4) ? 67 : 0;
            recv_idle_pct = (p < 2) ? 67 : (p < 4) ? 27 : 0;

            // random: mostly near notes, tolerance edges and ties
            for (int n = 0; n < RAND_PER_PHASE; n++)
            begin
                k   = $urandom_range(99);
                idx = $urandom_range(TABLE_N - 1);
                if (k < 40)
                begin
                    off = int'($urandom_range(600)) - 300;
                    freq_backlog.push_back(clamp_freq(note_freq[idx] + off));
                end
                else if (k < 55)
                begin
                    off = int'(tol_shadow) + int'($urandom_range(2)) - 1;
                    if ($urandom_range(1) == 0)
                    begin
                        off = -off;
                    end
                    freq_backlog.push_back(clamp_freq(note_freq[idx] + off));
                end
                else if (k < 60)
                begin
                    freq_backlog.push_back(clamp_freq(note_freq[idx]));
                end
                else if (k < 68)
                begin
                    off = $urandom_range(tie_points.size() - 1);
                    freq_backlog.push_back(clamp_freq(tie_points[off]));
                end
                else
                begin
                    freq_backlog.push_back(FREQ_W'($urandom_range(FREQ_MAX)));
                end
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (pending_notes.size() != 0)
        begin
            mismatch_cnt++;
        end
        if (mismatch_cnt == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
